>>> src/svl_pkg.sv
// svl_pkg: command and status codes and field widths for the sorted value list
// no dependencies; used by sorted_value_list
package svl_pkg;

   localparam int VALUE_W  = 32;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic signed [VALUE_W-1:0] value_type;

   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_SEARCH = 2'd1;
   localparam cmd_type CMD_DELETE = 2'd2;
   localparam cmd_type CMD_POP    = 2'd3;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_NOTFOUND = 2'd1;
   localparam status_type ST_FULL     = 2'd2;
   localparam status_type ST_EMPTY    = 2'd3;

endpackage

>>> src/sorted_value_list.sv
// sorted_value_list: ascending store of signed values with insert, search,
// delete and pop, walked one entry at a time over a single-port-read memory
// depends on svl_pkg
//
//  channel   direction  tdata                              tuser
//  req       in         value[31:0]                        cmd[1:0]
//  rsp       out        popped_value[31:0], count[36:32]   status[1:0]
//
// each memory step is a registered read then a compare and write
// insert shifts up every entry not smaller than the value, then writes it in;
// a full store, or an empty one on search, delete or pop, goes straight to the response
// search walks up from the first entry until a match or the end of the store;
// delete and pop (which takes the first entry) shift the later entries down
// reset clears the count, the sequencer and the response valid; entry contents stay undefined
// one transaction at a time; a new request is taken while a response still waits
module sorted_value_list #(
   parameter int DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [31:0]                   req_tdata,  // value[31:0]
   input  logic [svl_pkg::CMD_W-1:0]     req_tuser,  // cmd[1:0]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [39:0]                   rsp_tdata,  // popped_value[31:0], entry_count[36:32]
   output logic [svl_pkg::STATUS_W-1:0]  rsp_tuser   // status[1:0]
);
   import svl_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_FIND_RD  = 4'd1;
   localparam logic [3:0] S_FIND_CMP = 4'd2;
   localparam logic [3:0] S_UP_RD    = 4'd3;
   localparam logic [3:0] S_UP_WR    = 4'd4;
   localparam logic [3:0] S_UP_PUT   = 4'd5;
   localparam logic [3:0] S_DN_RD    = 4'd6;
   localparam logic [3:0] S_DN_WR    = 4'd7;
   localparam logic [3:0] S_DONE     = 4'd8;

   value_type mem [DEPTH];

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;
   cmd_type       cmd_ff, cmd_in;
   value_type     val_ff, val_in;
   status_type    status_ff, status_in;
   value_type     popped_ff, popped_in;
   value_type     rd_data_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [39:0]   rsp_data_ff, rsp_data_in;
   status_type    rsp_status_ff, rsp_status_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   value_type     wr_data;
   logic [CW-1:0] rd_idx;
   logic [CW:0]   idx_p1, idx_p2;
   logic          match;
   logic          req_take;

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign idx_p1     = {1'b0, idx_ff} + (CW+1)'(1);
   assign idx_p2     = {1'b0, idx_ff} + (CW+1)'(2);
   assign match      = (cmd_ff == CMD_POP) || (rd_data_ff == val_ff);

   always_comb begin
      unique case (state_ff)
         S_UP_RD: rd_idx = idx_ff - CW'(1);
         S_DN_RD: rd_idx = CW'(idx_p1);
         default: rd_idx = idx_ff;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      popped_in     = popped_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[AW-1:0];
      wr_data       = val_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_in    = req_tuser;
               val_in    = req_tdata;
               popped_in = '0;
               idx_in    = '0;
               status_in = ST_OK;
               unique case (req_tuser)
                  CMD_INSERT: begin
                     idx_in = count_ff;
                     if (count_ff == CW'(DEPTH)) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end else if (count_ff == '0) begin
                        state_in = S_UP_PUT;
                     end else begin
                        state_in = S_UP_RD;
                     end
                  end
                  CMD_SEARCH, CMD_DELETE: begin
                     status_in = ST_NOTFOUND;
                     state_in  = (count_ff == '0) ? S_DONE : S_FIND_RD;
                  end
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_FIND_RD;
                     end
                  end
               endcase
            end
         end
         S_FIND_RD: state_in = S_FIND_CMP;
         S_FIND_CMP: begin
            if (match) begin
               status_in = ST_OK;
               if (cmd_ff == CMD_POP) begin
                  popped_in = rd_data_ff;
               end
               if (cmd_ff == CMD_SEARCH) begin
                  state_in = S_DONE;
               end else if (idx_p1 >= {1'b0, count_ff}) begin
                  count_in = count_ff - CW'(1);
                  state_in = S_DONE;
               end else begin
                  state_in = S_DN_RD;
               end
            end else begin
               idx_in = CW'(idx_p1);
               state_in = (idx_p1 == {1'b0, count_ff}) ? S_DONE : S_FIND_RD;
            end
         end
         S_UP_RD: state_in = S_UP_WR;
         S_UP_WR: begin
            wr_en = 1'b1;
            if (rd_data_ff >= val_ff) begin
               wr_data = rd_data_ff;
               idx_in  = idx_ff - CW'(1);
               state_in = (idx_ff == CW'(1)) ? S_UP_PUT : S_UP_RD;
            end else begin
               count_in = count_ff + CW'(1);
               state_in = S_DONE;
            end
         end
         S_UP_PUT: begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
            state_in = S_DONE;
         end
         S_DN_RD: state_in = S_DN_WR;
         S_DN_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data_ff;
            idx_in  = CW'(idx_p1);
            if (idx_p2 >= {1'b0, count_ff}) begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end else begin
               state_in = S_DN_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = {3'b000, COUNT_W'(count_ff), popped_ff};
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      popped_ff     <= popped_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_idx[AW-1:0]];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && !rsp_tready) && status_ff == ST_FULL)
      |-> count_ff == CW'(DEPTH))
      else $error("full status while store not full");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && status_ff == ST_EMPTY) |-> count_ff == '0)
      else $error("empty status while store holds entries");

   a_popped_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && (status_ff != ST_OK || cmd_ff != CMD_POP))
      |-> popped_ff == '0)
      else $error("popped value set without a pop");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE) |-> !wr_en)
      else $error("memory write outside a walk");

endmodule
